/* design/lfu_cache_table_unit_assert.svh */
// Assertion macros shared by the LFU cache table RTL.
// Included by the controller and the datapath; no other dependencies.
`ifndef LFU_CACHE_TABLE_UNIT_ASSERT_SVH
`define LFU_CACHE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LFU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LFU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/lfu_pkg.sv */
// Package for the LFU cache table: widths, status codes, controller/datapath structs.
// No dependencies.
`default_nettype none

package lfu_pkg;

   localparam int LFU_ENTRIES    = 16;
   localparam int LFU_COUNT_BITS = 32;
   localparam int STAMP_BITS     = 64;
   localparam int KEY_BITS       = 32;
   localparam int VALUE_BITS     = 32;
   localparam int CAP_BITS       = 5;
   localparam int OCC_BITS       = 5;
   // holds any entry count up to 256 and the capacity register
   localparam int CMP_BITS       = 9;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   typedef enum logic [2:0] {
      ST_GET_MISS = 3'd0,
      ST_GET_HIT  = 3'd1,
      ST_UPDATE   = 3'd2,
      ST_INSERT   = 3'd3,
      ST_EVICT    = 3'd4,
      ST_DROPPED  = 3'd5,
      ST_OVERFLOW = 3'd6
   } status_type;

   typedef struct packed {
      logic       accept;
      logic       lookup;
      logic       scan_start;
      logic       scan_step;
      logic       hit_commit;
      logic       insert;
      logic       evict;
      logic       load_rsp;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic is_put;
      logic cap_zero;
      logic has_room;
      logic count_max;
      logic scan_last;
   } sts_type;

endpackage

`default_nettype wire

/* design/lfu_cache_table_unit.sv */
// LFU cache table top level: controller plus datapath.
// Depends on lfu_pkg, lfu_ctrl, lfu_dpath (and through it lfu_ram).
// Usage:
//  - req_*: one access per transfer (get or put, key, value), taken on a
//    rising edge with req_valid high and req_stall low.
//  - rsp_*: exactly one result per access, in order: status, read value
//    (get hit only, else zero), occupancy after the access.
//  - csr_*: capacity register, written whenever csr_write_enable is high;
//    write it only while the block is idle.
// Flow:
//  - Get, update, overflow, miss, drop and insert with a free slot: the
//    result is registered after accept, parallel key compare, RAM read and
//    commit; no new access is taken until the block is idle again.
//  - Insert into a full table: a victim scan that reads the entry RAM one
//    slot per cycle runs before the commit, and no new access is taken
//    until it is done.
// Reset clears the valid lanes, occupancy and stamp counter and sets capacity
// to 16; no clearing pass. While rsp_stall holds a result, the next request
// is still taken and processed; only loading its result waits.
`default_nettype none

module lfu_cache_table_unit #(
   parameter int ENTRIES    = lfu_pkg::LFU_ENTRIES,
   parameter int COUNT_BITS = lfu_pkg::LFU_COUNT_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_operation,
   input  wire logic signed [lfu_pkg::KEY_BITS-1:0]   req_lookup_key,
   input  wire logic signed [lfu_pkg::VALUE_BITS-1:0] req_write_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic             [2:0]                     rsp_status,
   output logic signed      [lfu_pkg::VALUE_BITS-1:0] rsp_read_value,
   output logic             [lfu_pkg::OCC_BITS-1:0]   rsp_occupancy,
   input  wire logic                                  csr_write_enable,
   input  wire logic        [lfu_pkg::CAP_BITS-1:0]   csr_write_data
);
   import lfu_pkg::*;

   cmd_type cmd;
   sts_type sts;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lfu_dpath #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_lookup_key   (req_lookup_key),
      .req_write_value  (req_write_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule

`default_nettype wire

/* design/lfu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lfu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/lfu_dpath.sv */
// LFU cache datapath: key/valid lanes, entry RAM, victim scan, response registers.
// Depends on lfu_pkg, lfu_ram and the assertion header.
`default_nettype none

`include "lfu_cache_table_unit_assert.svh"

module lfu_dpath #(
   parameter int ENTRIES    = lfu_pkg::LFU_ENTRIES,
   parameter int COUNT_BITS = lfu_pkg::LFU_COUNT_BITS
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire lfu_pkg::cmd_type                        cmd,
   output lfu_pkg::sts_type                             sts,
   input  wire logic                                    req_operation,
   input  wire logic signed [lfu_pkg::KEY_BITS-1:0]     req_lookup_key,
   input  wire logic signed [lfu_pkg::VALUE_BITS-1:0]   req_write_value,
   input  wire logic                                    csr_write_enable,
   input  wire logic        [lfu_pkg::CAP_BITS-1:0]     csr_write_data,
   output logic             [2:0]                       rsp_status,
   output logic signed      [lfu_pkg::VALUE_BITS-1:0]   rsp_read_value,
   output logic             [lfu_pkg::OCC_BITS-1:0]     rsp_occupancy
);
   import lfu_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RW = COUNT_BITS + STAMP_BITS + VALUE_BITS;
   localparam logic [CMP_BITS-1:0] ENTRIES_W = CMP_BITS'(ENTRIES);

   // request latch
   logic                  op_ff;
   logic [KEY_BITS-1:0]   key_req_ff;
   logic [VALUE_BITS-1:0] val_req_ff;
   logic [CAP_BITS-1:0]   cap_ff;

   // tag lanes
   logic [ENTRIES-1:0]    valid_ff;
   logic [KEY_BITS-1:0]   key_ff [ENTRIES];
   logic [CMP_BITS-1:0]   occ_ff;
   logic [STAMP_BITS-1:0] seq_ff;

   // lookup results
   logic          hit_ff;
   logic [IW-1:0] hit_idx_ff;
   logic [IW-1:0] free_idx_ff;
   logic          match_any;
   logic [IW-1:0] match_idx;
   logic [IW-1:0] free_idx;

   // scan
   logic [IW-1:0]         scan_idx_ff;
   logic                  cmp_valid_ff;
   logic [IW-1:0]         cmp_idx_ff;
   logic                  best_any_ff;
   logic [IW-1:0]         best_idx_ff;
   logic [COUNT_BITS-1:0] best_count_ff;
   logic [STAMP_BITS-1:0] best_stamp_ff;
   logic                  better;

   // entry RAM
   logic                  ram_we;
   logic [IW-1:0]         ram_waddr;
   logic [RW-1:0]         ram_wdata;
   logic [IW-1:0]         ram_raddr;
   logic [RW-1:0]         ram_rdata;
   logic [COUNT_BITS-1:0] rd_count;
   logic [STAMP_BITS-1:0] rd_stamp;
   logic [VALUE_BITS-1:0] rd_value;

   logic [CMP_BITS-1:0]   cap_w;
   logic [CMP_BITS-1:0]   cap_eff;
   logic [CMP_BITS-1:0]   occ_next;
   logic [IW-1:0]         slot;

   logic [2:0]            rsp_status_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic [OCC_BITS-1:0]   rsp_occ_ff;

   assign rd_value = ram_rdata[VALUE_BITS-1:0];
   assign rd_stamp = ram_rdata[VALUE_BITS +: STAMP_BITS];
   assign rd_count = ram_rdata[VALUE_BITS+STAMP_BITS +: COUNT_BITS];

   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      free_idx  = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (key_ff[i] == key_req_ff)) begin
            match_any = 1'b1;
            match_idx = IW'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   assign cap_w   = CMP_BITS'(cap_ff);
   assign cap_eff = (cap_w > ENTRIES_W) ? ENTRIES_W : cap_w;

   // strict compare keeps the lowest index on a full tie
   assign better = !best_any_ff || (rd_count < best_count_ff) ||
                   ((rd_count == best_count_ff) && (rd_stamp < best_stamp_ff));

   always_comb begin
      priority if (cmd.lookup) begin
         ram_raddr = match_idx;
      end else if (cmd.scan_step) begin
         ram_raddr = scan_idx_ff;
      end else begin
         ram_raddr = hit_idx_ff;
      end
   end

   assign slot      = cmd.evict ? best_idx_ff : free_idx_ff;
   assign ram_we    = cmd.hit_commit || cmd.insert;
   assign ram_waddr = cmd.hit_commit ? hit_idx_ff : slot;
   always_comb begin
      if (cmd.hit_commit) begin
         ram_wdata = {rd_count + COUNT_BITS'(1), seq_ff, op_ff ? val_req_ff : rd_value};
      end else begin
         ram_wdata = {COUNT_BITS'(1), seq_ff, val_req_ff};
      end
   end

   assign occ_next = (cmd.insert && !cmd.evict) ? occ_ff + CMP_BITS'(1) : occ_ff;

   lfu_ram #(
      .WIDTH (RW),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         occ_ff       <= '0;
         seq_ff       <= '0;
         cap_ff       <= CAP_RESET;
         cmp_valid_ff <= 1'b0;
         best_any_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         if (cmd.insert) begin
            valid_ff[slot] <= 1'b1;
         end
         if (ram_we) begin
            seq_ff <= seq_ff + STAMP_BITS'(1);
         end
         occ_ff       <= occ_next;
         cmp_valid_ff <= cmd.scan_step;
         if (cmd.scan_start) begin
            best_any_ff <= 1'b0;
         end else if (cmp_valid_ff && valid_ff[cmp_idx_ff] && better) begin
            best_any_ff <= 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff      <= req_operation;
         key_req_ff <= req_lookup_key;
         val_req_ff <= req_write_value;
      end
      if (cmd.insert) begin
         key_ff[slot] <= key_req_ff;
      end
      if (cmd.lookup) begin
         hit_ff      <= match_any;
         hit_idx_ff  <= match_idx;
         free_idx_ff <= free_idx;
      end
      if (cmd.scan_start) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + IW'(1);
      end
      cmp_idx_ff <= scan_idx_ff;
      if (cmp_valid_ff && valid_ff[cmp_idx_ff] && better) begin
         best_idx_ff   <= cmp_idx_ff;
         best_count_ff <= rd_count;
         best_stamp_ff <= rd_stamp;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.code;
         rsp_value_ff  <= (cmd.code == ST_GET_HIT) ? rd_value : '0;
         rsp_occ_ff    <= occ_next[OCC_BITS-1:0];
      end
   end

   assign sts.hit       = hit_ff;
   assign sts.is_put    = op_ff;
   assign sts.cap_zero  = (cap_ff == '0);
   assign sts.has_room  = (occ_ff < cap_eff);
   assign sts.count_max = (rd_count == '1);
   assign sts.scan_last = (scan_idx_ff == IW'(ENTRIES - 1));

   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_occupancy  = rsp_occ_ff;

   `LFU_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ_ff <= ENTRIES_W,
      "occupancy above entry count")
   `LFU_ASSERT_NOW(a_free_slot, clock, reset, cmd.insert && !cmd.evict,
      !valid_ff[free_idx_ff], "insert into an occupied slot")
   `LFU_ASSERT_NOW(a_hit_valid, clock, reset, cmd.hit_commit, valid_ff[hit_idx_ff],
      "hit commit on an empty slot")

endmodule

`default_nettype wire

/* design/lfu_ctrl.sv */
// LFU cache controller: sequences lookup, victim scan, commit and response.
// Depends on lfu_pkg and the assertion header.
`default_nettype none

`include "lfu_cache_table_unit_assert.svh"

module lfu_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire lfu_pkg::sts_type sts,
   output lfu_pkg::cmd_type      cmd
);
   import lfu_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_DECIDE,
      S_SCAN,
      S_SCAN_END,
      S_EVICT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      go;

   // a result can be loaded only when the output register is free or draining
   assign go = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      cmd      = '0;
      cmd.code = ST_GET_MISS;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            priority if (sts.hit) begin
               if (go) begin
                  cmd.load_rsp = 1'b1;
                  if (sts.count_max) begin
                     cmd.code = ST_OVERFLOW;
                  end else begin
                     cmd.hit_commit = 1'b1;
                     cmd.code       = sts.is_put ? ST_UPDATE : ST_GET_HIT;
                  end
                  state_in = S_IDLE;
               end
            end else if (!sts.is_put) begin
               if (go) begin
                  cmd.load_rsp = 1'b1;
                  cmd.code     = ST_GET_MISS;
                  state_in     = S_IDLE;
               end
            end else if (sts.cap_zero) begin
               if (go) begin
                  cmd.load_rsp = 1'b1;
                  cmd.code     = ST_DROPPED;
                  state_in     = S_IDLE;
               end
            end else if (sts.has_room) begin
               if (go) begin
                  cmd.insert   = 1'b1;
                  cmd.load_rsp = 1'b1;
                  cmd.code     = ST_INSERT;
                  state_in     = S_IDLE;
               end
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            state_in = S_EVICT;
         end
         S_EVICT: begin
            if (go) begin
               cmd.insert   = 1'b1;
               cmd.evict    = 1'b1;
               cmd.load_rsp = 1'b1;
               cmd.code     = ST_EVICT;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `LFU_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.load_rsp, go,
      "result loaded over a held result")
   `LFU_ASSERT_NEXT(a_accept_lookup, clock, reset, cmd.accept, state_ff == S_LOOKUP,
      "accepted item did not go to lookup")
   `LFU_ASSERT_NOW(a_insert_rsp, clock, reset, cmd.insert || cmd.hit_commit, cmd.load_rsp,
      "table change without a result")

endmodule

`default_nettype wire
